// ===== hdl/cubic_interp_sine_oscillator_assert.svh =====
// Assertion helpers for the RTL files; ciso_fifo.sv includes them.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef CUBIC_INTERP_SINE_OSCILLATOR_ASSERT_SVH
`define CUBIC_INTERP_SINE_OSCILLATOR_ASSERT_SVH

// same-cycle implication
`define CISO_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CISO_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/ciso_pkg.sv =====
`default_nettype none

package ciso_pkg;

    // config port
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned OFFSET_BITS   = 10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_INCREMENT = 1'b0,
        REG_PHASE_OFFSET    = 1'b1
    } t_cfg_reg;

    // lookup fraction, Q0.16
    localparam int unsigned FRAC_Q = 16;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // two Q30 multiplies: term * x^2
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // ROM entry k of a 2^tb table, amplitude 2^(sb-1)-1; elaboration only
    function automatic logic signed [31:0] sine_entry(input int unsigned k,
                                                      input int unsigned tb,
                                                      input int unsigned sb);
        logic [63:0]        amp;
        logic [63:0]        p;
        logic [63:0]        quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        logic signed [63:0] res;
        amp  = (64'd1 << (sb - 1)) - 64'd1;
        p    = 64'(k) << 2;
        quad = p >> tb;
        r    = p & ((64'd1 << tb) - 64'd1);
        if (quad[0]) begin
            r = (64'd1 << tb) - r;
        end
        x    = (HALF_PI_Q30 * r) >> tb;
        term = x;
        sum  = $signed(x);
        // Taylor series up to x^13
        term = sq_step(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * amp + (64'd1 << 29)) >> 30;
        if (v > amp) begin
            v = amp;
        end
        res = (quad >= 64'd2) ? -$signed(v) : $signed(v);
        return res[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ciso_fifo.sv =====
`default_nettype none

`include "cubic_interp_sine_oscillator_assert.svh"

module ciso_fifo
    import ciso_pkg::*;
#(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output t_q_flags          o_flags
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR   = $clog2(DEPTH);
    localparam int unsigned CNT   = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PTR-1:0] r_wr;
    logic [PTR-1:0] r_rd;
    logic [CNT-1:0] r_count;

    assign o_data        = r_mem[r_rd];
    assign o_flags.full  = (r_count == CNT'(DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CISO_ASSERT_IMP(a_no_push_full, i_push, !o_flags.full, "push into full queue")
    `CISO_ASSERT_IMP(a_no_pop_empty, i_pop, !o_flags.empty, "pop from empty queue")
    `CISO_ASSERT_NXT(a_push_counts, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== hdl/ciso_front.sv =====
`default_nettype none

module ciso_front
    import ciso_pkg::*;
#(
    parameter int unsigned ROM_DEPTH       = 1024,
    parameter int unsigned PHASE_FRAC_BITS = 22,
    localparam int unsigned TB             = $clog2(ROM_DEPTH),
    localparam int unsigned EW             = TB + FRAC_Q + 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_req_valid,
    output logic                          o_req_ready,
    input  wire logic                     i_req_last,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  t_q_flags                      i_q_flags,
    output logic                          o_push,
    output logic [EW-1:0]                 o_push_data
);

    localparam int unsigned PW = TB + PHASE_FRAC_BITS;
    localparam int unsigned IW = (PW > CFG_DATA_BITS) ? PW : CFG_DATA_BITS;

    logic signed [CFG_DATA_BITS-1:0]    r_inc;
    logic [OFFSET_BITS-1:0]             r_off;
    logic [PW-1:0]                      r_phase;
    logic [PW-1:0]                      n_phase;
    logic [IW-1:0]                      inc_ext;
    logic [TB-1:0]                      idx;
    logic [PHASE_FRAC_BITS+FRAC_Q-1:0]  frac_wide;
    logic                               accept;

    assign o_req_ready = !i_q_flags.full;
    assign accept      = i_req_valid && o_req_ready;

    // two's complement step, wrap is free at a power-of-two span
    assign inc_ext = IW'(r_inc);
    assign n_phase = r_phase + inc_ext[PW-1:0];

    assign idx       = r_phase[PW-1:PHASE_FRAC_BITS] + TB'(r_off);
    assign frac_wide = {r_phase[PHASE_FRAC_BITS-1:0], {FRAC_Q{1'b0}}} >> PHASE_FRAC_BITS;

    assign o_push      = accept;
    assign o_push_data = {i_req_last, idx, frac_wide[FRAC_Q-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= '0;
            r_off   <= '0;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    REG_PHASE_INCREMENT: r_inc <= i_cfg_data;
                    REG_PHASE_OFFSET:    r_off <= i_cfg_data[OFFSET_BITS-1:0];
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ciso_back.sv =====
`default_nettype none

module ciso_back
    import ciso_pkg::*;
#(
    parameter int unsigned ROM_DEPTH   = 1024,
    parameter int unsigned SAMPLE_BITS = 16,
    localparam int unsigned TB         = $clog2(ROM_DEPTH),
    localparam int unsigned EW         = TB + FRAC_Q + 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  t_q_flags                    i_q_flags,
    output logic                        o_pop,
    input  wire logic [EW-1:0]          i_q_data,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output logic                        o_last
);

    localparam int unsigned SB           = SAMPLE_BITS;
    localparam int unsigned AW           = SB + 4;          // coefficient width
    localparam int unsigned TW           = SB + 14;         // Horner accumulator
    localparam int unsigned PRW          = TW + FRAC_Q + 1;
    localparam int unsigned HORNER_SHIFT = 8;               // scale 256
    localparam int unsigned DIV_SHIFT    = 9;               // 1536 = 512 * 3
    localparam int unsigned ROUND_BIAS   = 768;             // half of 1536
    localparam int unsigned UW           = TW - DIV_SHIFT;
    localparam int unsigned VW           = UW + 1;
    localparam int unsigned NSH          = VW + 2;
    localparam int unsigned RW           = NSH - 1;
    localparam int unsigned P3W          = VW + RW;
    localparam int unsigned QW           = P3W - NSH;
    localparam int unsigned SW           = QW + 1;
    localparam int unsigned READS        = 4;
    localparam int unsigned CW           = $clog2(READS + 1);

    // floor(v/3) = (v * RECIP) >> NSH for every v below 2^VW
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << NSH) + 64'd2) / 64'd3);
    // bias that keeps the dividend positive: 3*M, removed again as M
    localparam logic [VW-1:0]        BIAS3  = VW'(64'd3 << (SB + 4));
    localparam logic signed [SW-1:0] BIAS_M = SW'(64'd1 << (SB + 4));
    localparam logic signed [SW-1:0] SMAX   = SW'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [SW-1:0] SMIN   = ~SMAX;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_COEF = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_SAT  = 7'b1000000
    } t_state;

    // sine ROM, filled at elaboration
    logic signed [SB-1:0] rom [ROM_DEPTH];
    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        localparam logic signed [31:0] ENTRY = sine_entry(k, TB, SB);
        assign rom[k] = ENTRY[SB-1:0];
    end

    t_state                 r_state;
    logic [TB-1:0]          r_idx;
    logic [FRAC_Q-1:0]      r_frac;
    logic                   r_last_q;
    logic [CW-1:0]          r_cnt;
    logic [1:0]             r_step;
    logic signed [SB-1:0]   r_rom_q;
    logic signed [SB-1:0]   r_y0, r_y1, r_y2, r_y3;
    logic signed [AW-1:0]   r_a2, r_a1, r_a0;
    logic signed [TW-1:0]   r_t;
    logic signed [PRW-1:0]  r_prod;
    logic [P3W-1:0]         r_prod3;
    logic                   r_ovalid;
    logic [SB-1:0]          r_sample;
    logic                   r_olast;

    logic [TB-1:0]          rom_addr;
    logic signed [AW-1:0]   ye0, ye1, ye2, ye3;
    logic signed [AW-1:0]   d12, s02;
    logic signed [AW-1:0]   a3, a2, a1, a0;
    logic signed [AW-1:0]   coef;
    logic signed [TW-1:0]   tr;
    logic signed [UW-1:0]   u;
    logic [VW-1:0]          v;
    logic [QW-1:0]          q;
    logic signed [SW-1:0]   s;
    logic [SB-1:0]          s_sat;
    logic                   out_free;
    logic                   load_out;

    assign o_pop    = (r_state == S_IDLE) && !i_q_flags.empty;
    assign out_free = !r_ovalid || i_tready;
    assign load_out = (r_state == S_SAT) && out_free;

    // neighbors idx-1 .. idx+2, one read a cycle
    assign rom_addr = r_idx + TB'(r_cnt) - TB'(1);

    always_ff @(posedge i_clk) begin
        r_rom_q <= rom[rom_addr];
    end

    // Lagrange coefficients, times 6
    assign ye0 = AW'(r_y0);
    assign ye1 = AW'(r_y1);
    assign ye2 = AW'(r_y2);
    assign ye3 = AW'(r_y3);
    assign d12 = ye1 - ye2;
    assign s02 = ye0 + ye2;
    assign a3  = (d12 <<< 1) + d12 + ye3 - ye0;
    assign a2  = (s02 <<< 1) + s02 - (ye1 <<< 2) - (ye1 <<< 1);
    assign a1  = (ye2 <<< 2) + (ye2 <<< 1) - (ye0 <<< 1) - ye3 - (ye1 <<< 1) - ye1;
    assign a0  = (ye1 <<< 2) + (ye1 <<< 1);

    always_comb begin
        unique case (r_step)
            2'd0:    coef = r_a2;
            2'd1:    coef = r_a1;
            default: coef = r_a0;
        endcase
    end

    // round half up of t/1536 as floor(floor((t+768)/512)/3)
    assign tr = r_t + TW'(ROUND_BIAS);
    assign u  = tr[TW-1:DIV_SHIFT];
    assign v  = {u[UW-1], u} + BIAS3;
    assign q  = r_prod3[P3W-1:NSH];
    assign s  = $signed({1'b0, q}) - BIAS_M;

    always_comb begin
        priority if (s > SMAX) begin
            s_sat = SMAX[SB-1:0];
        end else if (s < SMIN) begin
            s_sat = SMIN[SB-1:0];
        end else begin
            s_sat = s[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_frac   <= i_q_data[FRAC_Q-1:0];
                        r_idx    <= i_q_data[FRAC_Q+TB-1:FRAC_Q];
                        r_last_q <= i_q_data[EW-1];
                        r_cnt    <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0) begin
                        r_y0 <= r_y1;
                        r_y1 <= r_y2;
                        r_y2 <= r_y3;
                        r_y3 <= r_rom_q;
                    end
                    if (r_cnt == CW'(READS)) begin
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    r_t     <= TW'(a3) <<< HORNER_SHIFT;
                    r_a2    <= a2;
                    r_a1    <= a1;
                    r_a0    <= a0;
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_t * $signed({1'b0, r_frac});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_t    <= TW'(r_prod >>> FRAC_Q) + (TW'(coef) <<< HORNER_SHIFT);
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd2) begin
                        r_state <= S_RND;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_RND: begin
                    r_prod3 <= v * RECIP;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (out_free) begin
                        r_sample <= s_sat;
                        r_olast  <= r_last_q;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_sample = r_sample;
    assign o_last   = r_olast;

endmodule

`default_nettype wire

// ===== hdl/cubic_interp_sine_oscillator.sv =====
// Cubic-interpolating DDS sine oscillator.
// Slave stream: each word is one sample request; s_axis_tdata bit 0 flags the
// last request of a block. Master stream: one sample word per request, in order;
// m_axis_tlast copies that flag.
// Config: i_cfg_we writes register i_cfg_addr (0 = phase increment, signed,
// 22 fraction bits; 1 = phase offset in whole entries). Write only while idle.
// Front end: takes a request, forms table index and Q0.16 fraction from the
// phase, advances the phase and queues the job (2 entries), so up to two
// requests are taken ahead of the datapath.
// Back end: 4 ROM reads through one registered read port, then three Horner
// steps on one shared multiplier, a reciprocal multiply for the /3 and a
// saturation stage.
// The back end takes one job at a time, paced by the ROM port and the shared
// multiplier, through S_READ, S_COEF, S_MUL/S_ACC, S_RND and S_SAT to the output.
// Stall: the sample sits in an output register; the back end finishes its next
// sample and waits for that register, the front end keeps taking requests
// until the queue fills.
// Reset (i_rst_n low, synchronous): phase and both registers go to zero,
// queue and output empty. The ROM is constant; no clearing pass.
// ROM_DEPTH must be a power of two.
`default_nettype none

module cubic_interp_sine_oscillator
    import ciso_pkg::*;
#(
    parameter int unsigned ROM_DEPTH       = 1024,
    parameter int unsigned PHASE_FRAC_BITS = 22,
    parameter int unsigned SAMPLE_BITS     = 16,
    localparam int unsigned ODW            = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // config write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // request stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,   // [0] last_request
    // sample stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [ODW-1:0]                m_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                          m_axis_tlast
);

    localparam int unsigned TB = $clog2(ROM_DEPTH);
    localparam int unsigned EW = TB + FRAC_Q + 1;   // {last, index, fraction}

    t_q_flags               q_flags;
    logic                   push;
    logic [EW-1:0]          push_data;
    logic                   pop;
    logic [EW-1:0]          pop_data;
    logic [SAMPLE_BITS-1:0] sample;

    ciso_front #(
        .ROM_DEPTH       (ROM_DEPTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_last  (s_axis_tdata[0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_q_flags   (q_flags),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // job queue between the two halves
    ciso_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_flags (q_flags)
    );

    ciso_back #(
        .ROM_DEPTH   (ROM_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_flags (q_flags),
        .o_pop     (pop),
        .i_q_data  (pop_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_sample  (sample),
        .o_last    (m_axis_tlast)
    );

    // zero fill to whole bytes
    assign m_axis_tdata = ODW'(sample);

endmodule

`default_nettype wire
